/* src/gb3_pkg.sv */
// Shared constants and types of the 3x3 Gaussian blur stream.
package gb3_pkg;

  localparam int MaxLine = 1024;
  localparam int AddrW   = $clog2(MaxLine);
  localparam int PixW    = 8;
  localparam int LwW     = 11;
  localparam int FhW     = 16;
  localparam int ColOutW = 10;
  localparam int CfgIdxW = 1;
  localparam int CfgDatW = 16;
  localparam int SumW    = PixW + 4;
  localparam int CmpW    = (AddrW + 1 > LwW + 1) ? AddrW + 1 : LwW + 1;

  localparam logic [LwW-1:0] LineWidthReset   = LwW'(640);
  localparam logic [FhW-1:0] FrameHeightReset = FhW'(480);
  localparam logic [CmpW-1:0] MaxLineCmp      = CmpW'(MaxLine);

  localparam logic [CfgIdxW-1:0] CfgLineWidth   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = CfgIdxW'(1);

  typedef logic [PixW-1:0] pix_t;

endpackage

/* src/gb3_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module gb3_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/gaussian_blur_3x3_stream.sv */
// Streaming 3x3 Gaussian blur with line buffers held in RAM.
//
// Pixels enter in raster order, one per clock when the output side keeps up;
// the line RAM takes one read (at accept) and one write (as the pixel leaves
// the second stage) for every pixel. A result reaches the output register as
// the pixel that completes its window leaves the second stage. Each pixel at
// row r >= 2 and column c >= 2 yields the blurred value of centre (r-1, c-1)
// with its coordinates; border centres give no result, and the last interior
// result of a frame carries frame_done. Both line rows live in one 16-bit wide
// RAM that needs no clearing pass after reset. The user must write line_width
// (0 read as 1, capped at the RAM depth) and frame_height (0 read as 1) through
// the configuration port only while the block is idle; the block never checks.
module gaussian_blur_3x3_stream
  import gb3_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PixW-1:0]    pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PixW-1:0]    blurred_o,
  output logic [FhW-1:0]     center_row_o,
  output logic [ColOutW-1:0] center_col_o,
  output logic               frame_done_o
);

  logic [LwW-1:0] line_width_q;
  logic [FhW-1:0] frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineWidthReset;
      frame_height_q <= FrameHeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgLineWidth:   line_width_q   <= cfg_data_i[LwW-1:0];
        CfgFrameHeight: frame_height_q <= cfg_data_i[FhW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame geometry.
  logic [CmpW-1:0] lw_ext, eff_w;
  logic [FhW:0]    eff_h;

  assign lw_ext = CmpW'(line_width_q);
  always_comb begin
    if (lw_ext == '0) begin
      eff_w = CmpW'(1);
    end else if (lw_ext > MaxLineCmp) begin
      eff_w = MaxLineCmp;
    end else begin
      eff_w = lw_ext;
    end
    eff_h = (frame_height_q == '0) ? (FhW+1)'(1) : {1'b0, frame_height_q};
  end

  // Position counters, advanced at every accepted pixel.
  logic [FhW-1:0]   row_q, row_d;
  logic [AddrW-1:0] col_q, col_d;
  logic [CmpW-1:0]  col_p1;
  logic [FhW:0]     row_p1;
  logic             in_acc;

  assign in_acc = in_valid_i && in_ready_o;
  assign col_p1 = CmpW'(col_q) + CmpW'(1);
  assign row_p1 = {1'b0, row_q} + (FhW+1)'(1);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (col_p1 >= eff_w) begin
      col_d = '0;
      row_d = (row_p1 >= eff_h) ? '0 : row_p1[FhW-1:0];
    end else begin
      col_d = col_p1[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Second stage: line RAM data arrives, window shifts, result is formed.
  logic             s1_valid_q;
  logic             s1_emit_q;
  logic             s1_done_q;
  logic [FhW-1:0]   s1_row_q;
  logic [AddrW-1:0] s1_col_q;
  logic [AddrW-1:0] s1_addr_q;
  pix_t             s1_pix_q;
  logic             s1_fwd_q;
  logic [2*PixW-1:0] fwd_data_q;
  logic             s1_adv;
  logic             out_valid_q;

  logic [2*PixW-1:0] ram_rdata, line_rd, line_wd;
  pix_t              top, mid;

  assign s1_adv     = s1_valid_q && (!s1_emit_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // The pixel accepted right behind one at the same column would read the
  // line RAM before that write lands, so the written pair is forwarded.
  assign line_rd = s1_fwd_q ? fwd_data_q : ram_rdata;
  assign top     = line_rd[2*PixW-1:PixW];
  assign mid     = line_rd[PixW-1:0];
  assign line_wd = {mid, s1_pix_q};

  gb3_ram #(
    .Width (2 * PixW),
    .Depth (MaxLine)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wd),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_emit_q  <= (row_q >= FhW'(2)) && (col_q >= AddrW'(2));
      s1_done_q  <= (row_p1 == eff_h) && (col_p1 == eff_w);
      s1_row_q   <= row_q - FhW'(1);
      s1_col_q   <= col_q - AddrW'(1);
      s1_addr_q  <= col_q;
      s1_pix_q   <= pixel_i;
      s1_fwd_q   <= s1_adv && (s1_addr_q == col_q);
      fwd_data_q <= line_wd;
    end
  end

  // Window: entries 0..2 are the older column (top, mid, bottom), 3..5 the newer.
  pix_t win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= s1_pix_q;
    end
  end

  logic [SumW-1:0] sum, sum_rnd;

  assign sum = SumW'(win_q[0]) + SumW'(top) + SumW'(win_q[2]) + SumW'(s1_pix_q)
             + ((SumW'(win_q[3]) + SumW'(win_q[1]) + SumW'(mid) + SumW'(win_q[5])) << 1)
             + (SumW'(win_q[4]) << 2);
  assign sum_rnd = sum + SumW'(8);

  // Output register.
  pix_t             blurred_q;
  logic [FhW-1:0]   center_row_q;
  logic [ColOutW-1:0] center_col_q;
  logic             frame_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      blurred_q    <= sum_rnd[SumW-1:4];
      center_row_q <= s1_row_q;
      center_col_q <= ColOutW'(s1_col_q);
      frame_done_q <= s1_done_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign blurred_o    = blurred_q;
  assign center_row_o = center_row_q;
  assign center_col_o = center_col_q;
  assign frame_done_o = frame_done_q;

endmodule
